@@ rtl/bounded_array_table_engine_defines.svh @@
`ifndef BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BATE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BATE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bate_pkg.sv @@
package bate_pkg;

	localparam int MODE_W  = 4;
	localparam int POS_W   = 6;
	localparam int OPND_W  = 32;
	localparam int STAT_W  = 3;
	localparam int FOUND_W = 6;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 4'd0,
		MODE_POP    = 4'd1,
		MODE_INSERT = 4'd2,
		MODE_OREM   = 4'd3,
		MODE_UREM   = 4'd4,
		MODE_LSRCH  = 4'd5,
		MODE_BSRCH  = 4'd6,
		MODE_READ   = 4'd7,
		MODE_WRITE  = 4'd8,
		MODE_CLEAR  = 4'd9
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_RANGE    = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CO_HOLD   = 3'd0,
		CO_INSERT = 3'd1,
		CO_CLOSE  = 3'd2,
		CO_SWAP   = 3'd3,
		CO_WRITE  = 3'd4,
		CO_CLEAR  = 3'd5
	} cell_op_t;

	typedef struct packed {
		logic start;
		logic binary;
	} srch_cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
	} srch_rsp_t;

endpackage

@@ rtl/bate_if.sv @@
interface bate_req_if;
	logic                         valid;
	logic                         ready;
	logic [bate_pkg::MODE_W-1:0]  mode;
	logic [bate_pkg::POS_W-1:0]   position;
	logic [bate_pkg::OPND_W-1:0]  operand;

	modport source (output valid, mode, position, operand, input ready);
	modport sink (input valid, mode, position, operand, output ready);
endinterface

interface bate_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bate_pkg::STAT_W-1:0]   status;
	logic [bate_pkg::FOUND_W-1:0]  found_at;
	logic [bate_pkg::DATA_W-1:0]   data_out;
	logic [bate_pkg::COUNT_W-1:0]  count;

	modport source (output valid, status, found_at, data_out, count, input ready);
	modport sink (input valid, status, found_at, data_out, count, output ready);
endinterface

@@ rtl/bounded_array_table_engine.sv @@
// Fixed-capacity table of DEPTH elements held in a row of cells, one element per cell, with a
// live count. Each request word gets exactly one response word. Push, pop, insert, both removes,
// read, write and clear pass through a check state that also reads the addressed cell, a fetch
// state that reads the last live cell, and an apply state in which the cells the operation touches
// load from a neighbor, the key, the last element or zero at once. Linear search has the match
// flags of all cells registered and then priority-encoded in one step. Binary search walks the
// registered flags one probe per cycle until it hits the key or its range closes. A stalled
// response port holds the engine in its emit state. The request port takes one word at a time;
// the finished response sits in an output register so it can wait without blocking the last
// update.
module bounded_array_table_engine #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	bate_req_if.sink   req,
	bate_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > bate_pkg::POS_W) ? CW : bate_pkg::POS_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_APPLY = 6'b001000,
		ST_SRCH  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic                   out_valid_q;

	bate_pkg::mode_t        mode_q;
	logic [XW-1:0]          pos_q;
	logic [ELEM_WIDTH-1:0]  val_q;
	bate_pkg::status_t      status_q;
	bate_pkg::cell_op_t     op_q;
	logic [XW-1:0]          tgt_q;
	logic [CW-1:0]          cnt_nxt_q;
	logic [ELEM_WIDTH-1:0]  data_q;
	logic [ELEM_WIDTH-1:0]  last_q;
	logic [AW-1:0]          found_q;

	logic [bate_pkg::STAT_W-1:0]  out_status_q;
	logic [bate_pkg::FOUND_W-1:0] out_found_q;
	logic [bate_pkg::DATA_W-1:0]  out_data_q;
	logic [bate_pkg::COUNT_W-1:0] out_count_q;

	logic [XW-1:0]          n_x;
	logic                   is_full;
	logic                   is_empty;
	bate_pkg::status_t      chk_status;
	bate_pkg::cell_op_t     chk_op;
	logic [XW-1:0]          chk_tgt;
	logic [CW-1:0]          chk_cnt;
	logic                   chk_rd;
	logic                   chk_srch;

	logic [XW-1:0]          rd_addr;
	logic [ELEM_WIDTH-1:0]  rd_data;
	logic                   out_free;
	logic                   load;
	bate_pkg::cell_op_t     cell_op;

	logic [ELEM_WIDTH-1:0]  elem [DEPTH];
	logic [ELEM_WIDTH-1:0]  lft  [DEPTH];
	logic [ELEM_WIDTH-1:0]  rgt  [DEPTH];
	logic [DEPTH-1:0]       eq_vec;
	logic [DEPTH-1:0]       gt_vec;

	bate_pkg::srch_cmd_t    srch_cmd;
	bate_pkg::srch_rsp_t    srch_rsp;
	logic [AW-1:0]          srch_idx;

	assign n_x      = XW'(cnt_q);
	assign is_full  = (cnt_q == CW'(DEPTH));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		chk_status = bate_pkg::STAT_OK;
		chk_op     = bate_pkg::CO_HOLD;
		chk_tgt    = pos_q;
		chk_cnt    = cnt_q;
		chk_rd     = 1'b0;
		chk_srch   = 1'b0;
		unique case (mode_q)
			bate_pkg::MODE_PUSH: begin
				if (is_full) begin
					chk_status = bate_pkg::STAT_FULL;
				end else begin
					chk_op  = bate_pkg::CO_INSERT;
					chk_tgt = n_x;
					chk_cnt = cnt_q + CW'(1);
				end
			end
			bate_pkg::MODE_POP: begin
				if (is_empty) begin
					chk_status = bate_pkg::STAT_EMPTY;
				end else begin
					chk_rd  = 1'b1;
					chk_tgt = n_x - XW'(1);
					chk_cnt = cnt_q - CW'(1);
				end
			end
			bate_pkg::MODE_INSERT: begin
				if (is_full) begin
					chk_status = bate_pkg::STAT_FULL;
				end else if (pos_q > n_x) begin
					chk_status = bate_pkg::STAT_RANGE;
				end else begin
					chk_op  = bate_pkg::CO_INSERT;
					chk_cnt = cnt_q + CW'(1);
				end
			end
			bate_pkg::MODE_OREM, bate_pkg::MODE_UREM: begin
				if (is_empty) begin
					chk_status = bate_pkg::STAT_EMPTY;
				end else if (pos_q >= n_x) begin
					chk_status = bate_pkg::STAT_RANGE;
				end else begin
					chk_rd  = 1'b1;
					chk_op  = (mode_q == bate_pkg::MODE_OREM) ? bate_pkg::CO_CLOSE
						: bate_pkg::CO_SWAP;
					chk_cnt = cnt_q - CW'(1);
				end
			end
			bate_pkg::MODE_LSRCH, bate_pkg::MODE_BSRCH: begin
				chk_srch = 1'b1;
			end
			bate_pkg::MODE_READ, bate_pkg::MODE_WRITE: begin
				if (is_empty) begin
					chk_status = bate_pkg::STAT_EMPTY;
				end else if (pos_q >= n_x) begin
					chk_status = bate_pkg::STAT_RANGE;
				end else if (mode_q == bate_pkg::MODE_READ) begin
					chk_rd = 1'b1;
				end else begin
					chk_op = bate_pkg::CO_WRITE;
				end
			end
			bate_pkg::MODE_CLEAR: begin
				chk_op = bate_pkg::CO_CLEAR;
			end
			default: begin
			end
		endcase
	end

	// one read port over the row: addressed cell in check, last live cell in fetch
	assign rd_addr = (state_q == ST_FETCH) ? (n_x - XW'(1)) : chk_tgt;

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rd_addr == XW'(i)) begin
				rd_data = elem[i];
			end
		end
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign load     = ((state_q == ST_APPLY) || (state_q == ST_EMIT)) && out_free;
	assign cell_op  = (state_q == ST_APPLY) ? op_q : bate_pkg::CO_HOLD;

	assign srch_cmd.start  = (state_q == ST_CHECK) && chk_srch;
	assign srch_cmd.binary = (mode_q == bate_pkg::MODE_BSRCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= chk_srch ? ST_SRCH : ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					cnt_q   <= cnt_nxt_q;
					state_q <= out_free ? ST_IDLE : ST_EMIT;
				end
				ST_SRCH: begin
					if (srch_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			mode_q <= bate_pkg::mode_t'(req.mode);
			pos_q  <= XW'(req.position);
			val_q  <= ELEM_WIDTH'(req.operand);
		end
		if (state_q == ST_CHECK) begin
			status_q  <= chk_status;
			op_q      <= chk_op;
			tgt_q     <= chk_tgt;
			cnt_nxt_q <= chk_cnt;
			data_q    <= chk_rd ? rd_data : '0;
			found_q   <= '0;
		end
		if (state_q == ST_FETCH) begin
			last_q <= rd_data;
		end
		if (state_q == ST_SRCH && srch_rsp.done) begin
			status_q <= srch_rsp.hit ? bate_pkg::STAT_OK : bate_pkg::STAT_NOTFOUND;
			found_q  <= srch_rsp.hit ? srch_idx : '0;
		end
		if (load) begin
			out_status_q <= status_q;
			out_found_q  <= bate_pkg::FOUND_W'(found_q);
			out_data_q   <= bate_pkg::DATA_W'(data_q);
			out_count_q  <= bate_pkg::COUNT_W'(cnt_nxt_q);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign lft[g] = '0;
		end else begin : g_mid_l
			assign lft[g] = elem[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign rgt[g] = '0;
		end else begin : g_mid_r
			assign rgt[g] = elem[g+1];
		end

		bate_cell #(
			.ELEM_WIDTH(ELEM_WIDTH),
			.XW        (XW),
			.IDX       (g)
		) u_cell (
			.clk  (clk),
			.op   (cell_op),
			.pos  (tgt_q),
			.n    (n_x),
			.val  (val_q),
			.last (last_q),
			.left (lft[g]),
			.right(rgt[g]),
			.elem (elem[g]),
			.eq   (eq_vec[g]),
			.gt   (gt_vec[g])
		);
	end

	bate_search #(
		.DEPTH(DEPTH)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (srch_cmd),
		.n     (cnt_q),
		.eq_vec(eq_vec),
		.gt_vec(gt_vec),
		.rsp   (srch_rsp),
		.idx   (srch_idx)
	);

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.found_at = out_found_q;
	assign rsp.data_out = out_data_q;
	assign rsp.count    = out_count_q;

endmodule

@@ rtl/bate_cell.sv @@
module bate_cell #(
	parameter int ELEM_WIDTH = 32,
	parameter int XW         = 7,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  bate_pkg::cell_op_t    op,
	input  logic [XW-1:0]         pos,
	input  logic [XW-1:0]         n,
	input  logic [ELEM_WIDTH-1:0] val,
	input  logic [ELEM_WIDTH-1:0] last,
	input  logic [ELEM_WIDTH-1:0] left,
	input  logic [ELEM_WIDTH-1:0] right,
	output logic [ELEM_WIDTH-1:0] elem,
	output logic                  eq,
	output logic                  gt
);

	localparam logic [XW-1:0] SELF = XW'(IDX);
	localparam logic [XW-1:0] NEXT = XW'(IDX + 1);

	logic [ELEM_WIDTH-1:0] elem_q;
	logic                  eq_q;
	logic                  gt_q;

	always_ff @(posedge clk) begin
		eq_q <= (elem_q == val);
		gt_q <= (elem_q > val);
		unique case (op)
			bate_pkg::CO_HOLD: begin
			end
			bate_pkg::CO_INSERT: begin
				if (SELF == pos) begin
					elem_q <= val;
				end else if (SELF > pos && SELF <= n) begin
					elem_q <= left;
				end
			end
			bate_pkg::CO_CLOSE: begin
				if (SELF >= pos && NEXT < n) begin
					elem_q <= right;
				end
			end
			bate_pkg::CO_SWAP: begin
				if (SELF == pos) begin
					elem_q <= last;
				end
			end
			bate_pkg::CO_WRITE: begin
				if (SELF == pos) begin
					elem_q <= val;
				end
			end
			bate_pkg::CO_CLEAR: begin
				if (SELF < n) begin
					elem_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign elem = elem_q;
	assign eq   = eq_q;
	assign gt   = gt_q;

endmodule

@@ rtl/bate_search.sv @@
module bate_search #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bate_pkg::srch_cmd_t          cmd,
	input  logic [$clog2(DEPTH+1)-1:0]   n,
	input  logic [DEPTH-1:0]             eq_vec,
	input  logic [DEPTH-1:0]             gt_vec,
	output bate_pkg::srch_rsp_t          rsp,
	output logic [$clog2(DEPTH)-1:0]     idx
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam logic signed [CW:0] ONE = 1;

	logic                 busy_q;
	logic                 bin_q;
	logic                 done_q;
	logic                 hit_q;
	logic [AW-1:0]        idx_q;
	logic signed [CW:0]   lo_q;
	logic signed [CW:0]   hi_q;

	logic                 ff_hit;
	logic [AW-1:0]        ff_idx;
	logic signed [CW:0]   diff;
	logic signed [CW:0]   mid;
	logic [AW-1:0]        mid_idx;
	logic                 in_rng;

	// lowest live index whose cell matched
	always_comb begin
		ff_hit = 1'b0;
		ff_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (eq_vec[i] && (CW'(i) < n)) begin
				ff_hit = 1'b1;
				ff_idx = AW'(i);
			end
		end
	end

	assign in_rng  = (lo_q <= hi_q);
	assign diff    = hi_q - lo_q;
	assign mid     = lo_q + (diff >>> 1);
	assign mid_idx = mid[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bin_q  <= 1'b0;
			done_q <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				bin_q  <= cmd.binary;
				lo_q   <= '0;
				hi_q   <= $signed({1'b0, n}) - ONE;
			end else if (busy_q) begin
				if (!bin_q || !in_rng || eq_vec[mid_idx]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (gt_vec[mid_idx]) begin
					hi_q <= mid - ONE;
				end else begin
					lo_q <= mid + ONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cmd.start) begin
			if (!bin_q) begin
				hit_q <= ff_hit;
				idx_q <= ff_idx;
			end else if (!in_rng) begin
				hit_q <= 1'b0;
				idx_q <= '0;
			end else if (eq_vec[mid_idx]) begin
				hit_q <= 1'b1;
				idx_q <= mid_idx;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit  = hit_q;
	assign idx      = idx_q;

endmodule

@@ rtl/bate_checker.sv @@
`include "bounded_array_table_engine_defines.svh"

module bate_checker #(
	parameter int DEPTH = 64
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic [bate_pkg::STAT_W-1:0]  rsp_status,
	input logic [bate_pkg::FOUND_W-1:0] rsp_found_at,
	input logic [bate_pkg::DATA_W-1:0]  rsp_data_out,
	input logic [bate_pkg::COUNT_W-1:0] rsp_count
);

	// one word in flight: no new request the cycle after one is taken
	`BATE_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

	`BATE_ASSERT_NOW(a_found_only_ok, rsp_valid && rsp_found_at != '0, rsp_status == bate_pkg::STAT_OK, "match index on failed search")

	`BATE_ASSERT_NOW(a_data_only_ok, rsp_valid && rsp_data_out != '0, rsp_status == bate_pkg::STAT_OK, "data on failed request")

	`BATE_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == bate_pkg::STAT_FULL, rsp_count == bate_pkg::COUNT_W'(DEPTH), "full reported below capacity")

endmodule

bind bounded_array_table_engine bate_checker #(
	.DEPTH(DEPTH)
) u_bate_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_status  (rsp.status),
	.rsp_found_at(rsp.found_at),
	.rsp_data_out(rsp.data_out),
	.rsp_count   (rsp.count)
);

@@ verif/tb_bounded_array_table_engine.sv @@
import bate_pkg::*;

localparam int TBL_DEPTH = 64;

typedef struct {
	status_t              st;
	logic [FOUND_W-1:0]   found;
	logic [DATA_W-1:0]    data;
	logic [COUNT_W-1:0]   cnt;
} table_result_t;

class table_scoreboard;
	logic [DATA_W-1:0] cells [TBL_DEPTH];
	int                live;
	table_result_t     due_results [$];
	int                errors;
	int                mode_hits [16];
	int                stat_hits [8];
	int                peak;

	function new();
		foreach (cells[i])
			cells[i] = '0;
		live = 0;
		errors = 0;
		peak = 0;
		foreach (mode_hits[i])
			mode_hits[i] = 0;
		foreach (stat_hits[i])
			stat_hits[i] = 0;
	endfunction

	// advance the table by one accepted request word and queue its response
	function void apply_request(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
			logic [OPND_W-1:0] v);
		table_result_t r;
		int n;
		int lo;
		int hi;
		int mid;
		r.st = STAT_OK;
		r.found = '0;
		r.data = '0;
		n = live;
		case (m)
			MODE_PUSH: begin
				if (n >= TBL_DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					cells[n] = v;
					n++;
				end
			end
			MODE_POP: begin
				if (n == 0) begin
					r.st = STAT_EMPTY;
				end else begin
					r.data = cells[n-1];
					cells[n-1] = '0;
					n--;
				end
			end
			MODE_INSERT: begin
				if (n >= TBL_DEPTH) begin
					r.st = STAT_FULL;
				end else if (int'(p) > n) begin
					r.st = STAT_RANGE;
				end else begin
					for (int i = n; i > int'(p); i--)
						cells[i] = cells[i-1];
					cells[p] = v;
					n++;
				end
			end
			MODE_OREM, MODE_UREM: begin
				if (n == 0) begin
					r.st = STAT_EMPTY;
				end else if (int'(p) >= n) begin
					r.st = STAT_RANGE;
				end else begin
					r.data = cells[p];
					if (m == MODE_OREM) begin
						for (int i = p; i + 1 < n; i++)
							cells[i] = cells[i+1];
					end else begin
						cells[p] = cells[n-1];
					end
					cells[n-1] = '0;
					n--;
				end
			end
			MODE_LSRCH: begin
				r.st = STAT_NOTFOUND;
				for (int i = 0; i < n; i++) begin
					if (cells[i] == v) begin
						r.st = STAT_OK;
						r.found = FOUND_W'(i);
						break;
					end
				end
			end
			MODE_BSRCH: begin
				r.st = STAT_NOTFOUND;
				lo = 0;
				hi = n - 1;
				// probe order holds even when the contents are unsorted
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (cells[mid] == v) begin
						r.st = STAT_OK;
						r.found = FOUND_W'(mid);
						break;
					end else if (cells[mid] > v) begin
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
			end
			MODE_READ, MODE_WRITE: begin
				if (n == 0)
					r.st = STAT_EMPTY;
				else if (int'(p) >= n)
					r.st = STAT_RANGE;
				else if (m == MODE_READ)
					r.data = cells[p];
				else
					cells[p] = v;
			end
			MODE_CLEAR: begin
				for (int i = 0; i < n; i++)
					cells[i] = '0;
			end
			default: ;
		endcase
		live = n;
		if (n > peak)
			peak = n;
		r.cnt = COUNT_W'(n);
		mode_hits[m]++;
		stat_hits[r.st]++;
		due_results = {due_results, r};
	endfunction

	function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void compare_response(logic [STAT_W-1:0] st, logic [FOUND_W-1:0] fa,
			logic [DATA_W-1:0] d, logic [COUNT_W-1:0] c);
		table_result_t r;
		if (due_results.size() == 0) begin
			$display("%0t: response word with none expected, expected nothing, got status %0h",
				$time, st);
			errors++;
			return;
		end
		r = due_results.pop_front();
		check_field("status", DATA_W'(r.st), DATA_W'(st));
		check_field("found_at", DATA_W'(r.found), DATA_W'(fa));
		check_field("data_out", r.data, d);
		check_field("count", DATA_W'(r.cnt), DATA_W'(c));
	endfunction
endclass

module tb_bounded_array_table_engine;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENTS    = 12;
	localparam int SEG_ITEMS   = 80;
	localparam int LONG_HOLD   = 300;

	typedef enum {FLV_FILL, FLV_DRAIN, FLV_SORTED, FLV_MIXED} flavor_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   rsp_seen;

	table_scoreboard sb;

	bate_req_if req_bus ();
	bate_rsp_if rsp_bus ();

	bounded_array_table_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus.sink),
		.rsp    (rsp_bus.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one word after a gap, hold it until taken
	task automatic send_word(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
			logic [OPND_W-1:0] v, int gap);
		@(negedge clk);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.mode     <= m;
		req_bus.position <= p;
		req_bus.operand  <= v;
		do
			@(posedge clk);
		while (req_bus.ready !== 1'b1);
		sb.apply_request(m, p, v);
	endtask

	task automatic release_bus();
		@(negedge clk);
		req_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [OPND_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40 && sb.live > 0)
			return sb.cells[$urandom_range(0, sb.live - 1)];
		else if (r < 50)
			return '0;
		else if (r < 60)
			return '1;
		else if (r < 80)
			return OPND_W'($urandom_range(0, 63));
		else
			return $urandom;
	endfunction

	// span is the number of legal positions
	function automatic logic [POS_W-1:0] pick_pos(int span);
		if (span > 0 && $urandom_range(0, 9) < 7)
			return POS_W'($urandom_range(0, (span > TBL_DEPTH ? TBL_DEPTH : span) - 1));
		return POS_W'($urandom_range(0, TBL_DEPTH - 1));
	endfunction

	function automatic bit table_sorted();
		for (int i = 1; i < sb.live; i++)
			if (sb.cells[i-1] > sb.cells[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic gen_item(flavor_t flv, output logic [MODE_W-1:0] m,
			output logic [POS_W-1:0] p, output logic [OPND_W-1:0] v);
		int r;
		int i;
		r = $urandom_range(0, 99);
		v = pick_key();
		p = pick_pos(sb.live);
		case (flv)
			FLV_FILL: begin
				if (r < 55) begin
					m = MODE_PUSH;
				end else if (r < 85) begin
					m = MODE_INSERT;
					p = pick_pos(sb.live + 1);
				end else if (r < 92) begin
					m = MODE_LSRCH;
				end else begin
					m = MODE_W'($urandom_range(0, 15));
				end
			end
			FLV_DRAIN: begin
				if (r < 35)
					m = MODE_POP;
				else if (r < 55)
					m = MODE_OREM;
				else if (r < 75)
					m = MODE_UREM;
				else if (r < 85)
					m = MODE_READ;
				else if (r < 92)
					m = MODE_WRITE;
				else
					m = MODE_W'($urandom_range(0, 15));
			end
			FLV_SORTED: begin
				if (!table_sorted()) begin
					m = MODE_CLEAR;
				end else if (r < 40 && sb.live <= 40) begin
					m = MODE_INSERT;
					// sorted slot keeps the table in order
					for (i = 0; i < sb.live; i++)
						if (sb.cells[i] > v)
							break;
					p = POS_W'(i);
				end else if (r < 40) begin
					m = MODE_POP;
				end else if (r < 72) begin
					m = MODE_BSRCH;
				end else if (r < 80) begin
					m = MODE_OREM;
				end else if (r < 88) begin
					m = MODE_POP;
				end else if (r < 94) begin
					m = MODE_READ;
				end else begin
					m = MODE_LSRCH;
				end
			end
			default: begin
				if (r < 8) begin
					m = MODE_CLEAR + MODE_W'($urandom_range(1, 6));
				end else begin
					m = MODE_W'($urandom_range(0, 9));
					if (m == MODE_INSERT)
						p = pick_pos(sb.live + 1);
				end
			end
		endcase
	endtask

	initial begin : response_side
		int gap;
		rsp_bus.ready = 1'b0;
		rsp_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ((rsp_seen % 50) < 15)
				gap = 0;
			else
				gap = $urandom_range(0, 16);
			// one long hold so the engine backs up into its request port
			if (rsp_seen == 400)
				gap = LONG_HOLD;
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_bus.valid !== 1'b1);
			sb.compare_response(rsp_bus.status, rsp_bus.found_at, rsp_bus.data_out,
				rsp_bus.count);
			rsp_seen++;
		end
	end

	initial begin : request_side
		logic [MODE_W-1:0] m;
		logic [POS_W-1:0]  p;
		logic [OPND_W-1:0] v;
		flavor_t           flv;
		bit                burst;
		sb = new();
		req_bus.valid    = 1'b0;
		req_bus.mode     = '0;
		req_bus.position = '0;
		req_bus.operand  = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table corner cases
		send_word(MODE_POP, '0, '0, $urandom_range(0, 16));
		send_word(MODE_OREM, '0, '0, $urandom_range(0, 16));
		send_word(MODE_UREM, '0, '0, $urandom_range(0, 16));
		send_word(MODE_READ, '0, '0, $urandom_range(0, 16));
		send_word(MODE_WRITE, '0, '1, $urandom_range(0, 16));
		send_word(MODE_LSRCH, '0, '0, $urandom_range(0, 16));
		send_word(MODE_BSRCH, '0, '0, $urandom_range(0, 16));
		send_word(MODE_INSERT, 6'd1, 32'h1, $urandom_range(0, 16));
		// build a small unsorted table
		send_word(MODE_INSERT, '0, '1, $urandom_range(0, 16));
		send_word(MODE_PUSH, '1, '0, $urandom_range(0, 16));
		send_word(MODE_INSERT, 6'd2, 32'd5, $urandom_range(0, 16));
		send_word(MODE_INSERT, 6'd1, 32'h8000_0000, $urandom_range(0, 16));
		send_word(MODE_READ, '1, '0, $urandom_range(0, 16));
		send_word(MODE_WRITE, 6'd4, 32'h1234, $urandom_range(0, 16));
		send_word(MODE_WRITE, 6'd3, 32'h7fff_ffff, $urandom_range(0, 16));
		send_word(MODE_READ, 6'd3, '0, $urandom_range(0, 16));
		send_word(MODE_LSRCH, '0, 32'h8000_0000, $urandom_range(0, 16));
		send_word(MODE_LSRCH, '0, 32'd12345, $urandom_range(0, 16));
		send_word(MODE_BSRCH, '0, 32'd5, $urandom_range(0, 16));
		send_word(MODE_OREM, '0, '0, $urandom_range(0, 16));
		send_word(MODE_UREM, '0, '0, $urandom_range(0, 16));
		send_word(MODE_CLEAR + MODE_W'(6), '1, '1, $urandom_range(0, 16));
		send_word(MODE_CLEAR, '0, '0, $urandom_range(0, 16));
		send_word(MODE_READ, '0, '0, $urandom_range(0, 16));
		send_word(MODE_POP, '0, '0, $urandom_range(0, 16));
		release_bus();
		wait_drained();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 0)
				flv = FLV_FILL;
			else if (seg == 1)
				flv = FLV_SORTED;
			else if (seg == 2)
				flv = FLV_DRAIN;
			else
				flv = flavor_t'($urandom_range(0, 3));
			burst = ($urandom_range(0, 2) == 0);
			if (seg == SEGMENTS / 2) begin
				// sender pause: let every response come home first
				release_bus();
				wait_drained();
			end
			for (int k = 0; k < SEG_ITEMS; k++) begin
				gen_item(flv, m, p, v);
				send_word(m, p, v, burst ? 0 : $urandom_range(0, 16));
			end
		end

		release_bus();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d requests over %0d random segments, table peaked at %0d entries",
			rsp_seen, SEGMENTS, sb.peak);
		$display("flags seen: %0d full, %0d empty, %0d out of range, %0d key misses",
			sb.stat_hits[STAT_FULL], sb.stat_hits[STAT_EMPTY], sb.stat_hits[STAT_RANGE],
			sb.stat_hits[STAT_NOTFOUND]);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
